// File: sv/mavg_pkg.sv
// Shared types and constants for the moving average with step reset.
package mavg_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 15;
	localparam int WLEN_W      = 4;
	localparam int THRESH_W    = 15;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_JUMP_THRESHOLD = 2'd1;

	// Register reset values (threshold is 0.01 rad in Q3.12)
	localparam logic [WLEN_W-1:0]   WLEN_RESET   = 4'd8;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd41;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_DROP,
		ST_APPEND,
		ST_DIV,
		ST_WAIT,
		ST_OUT
	} mavg_state_t;

endpackage

// File: sv/mavg_div.sv
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle.
module mavg_div #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] numer,
	input  logic        [DEN_W-1:0] denom,
	output logic                    busy,
	output logic                    done,
	output logic signed [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;

	logic [NUM_W-1:0] numer_mag;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Magnitude of the dividend and one restoring step
	always_comb begin
		numer_mag = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
		trial     = {rem_q, quo_q[NUM_W-1]};
		fits      = trial >= {1'b0, denom};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out the top, quotient bits shift in the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer_mag;
			rem_q <= '0;
			neg_q <= numer[NUM_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, denom}) : DEN_W'(trial);
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? NUM_W'(-quo_q) : NUM_W'(quo_q);

endmodule

// File: sv/moving_average_with_step_reset.sv
// Top level: windowed moving average with restart on a step, sequenced datapath.
// Sequence per input transaction: check, append, an iterative SUM_W-bit divide,
// output load, plus a read and a drop for each sample dropped from the ring.
// A new item is taken only after the last result is loaded; in_ready is high only while the sequencer
// idles, and a result held by out_ready keeps the next item off.
// Reset: arst_n empties the window and loads length 8, threshold 41; the ring is not cleared.
module moving_average_with_step_reset #(
	parameter int WINDOW_DEPTH = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Input channel
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [SAMPLE_BITS-1:0]           sample,
	// Output channel
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [SAMPLE_BITS-1:0]           average,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0]       sample_count,
	output logic                                    window_full,
	// Configuration channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [mavg_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [mavg_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W  = SAMPLE_BITS + PTR_W;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int CMP_W  = (DIFF_W > mavg_pkg::THRESH_W) ? DIFF_W : mavg_pkg::THRESH_W;

	mavg_pkg::mavg_state_t state_q, state_d;

	// Configuration registers
	logic [mavg_pkg::WLEN_W-1:0]   wlen_q;
	logic [mavg_pkg::THRESH_W-1:0] thresh_q;

	// Window state
	logic [PTR_W-1:0]              oldest_q;
	logic [CNT_W-1:0]              fill_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] newest_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic                          appended_q;

	// Ring memory
	logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic                          ring_we;
	logic [PTR_W-1:0]              slot;
	logic [CNT_W:0]                slot_raw;

	// Output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] average_q;
	logic [CNT_W-1:0]              count_q;
	logic                          full_q;

	// Combinational helpers
	logic [CNT_W-1:0]              eff_len;
	logic signed [DIFF_W-1:0]      diff;
	logic [DIFF_W-1:0]             diff_mag;
	logic                          jump;
	logic                          out_free;

	// Divider
	logic                          div_start;
	logic                          div_busy;
	logic                          div_done;
	logic signed [SUM_W-1:0]       div_quo;

	// Configuration writes, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= mavg_pkg::WLEN_RESET;
			thresh_q <= mavg_pkg::THRESH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mavg_pkg::REG_WINDOW_LENGTH:  wlen_q   <= cfg_data[mavg_pkg::WLEN_W-1:0];
				mavg_pkg::REG_JUMP_THRESHOLD: thresh_q <= cfg_data[mavg_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective length, jump test and append slot
	always_comb begin
		if (wlen_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(wlen_q) > 32'(WINDOW_DEPTH)) begin
			eff_len = CNT_W'(WINDOW_DEPTH);
		end else begin
			eff_len = CNT_W'(wlen_q);
		end

		diff     = DIFF_W'(smp_q) - DIFF_W'(newest_q);
		diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		jump     = (fill_q != '0) && (CMP_W'(diff_mag) > CMP_W'(thresh_q));

		slot_raw = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(fill_q);
		if (slot_raw >= (CNT_W+1)'(WINDOW_DEPTH)) begin
			slot_raw = slot_raw - (CNT_W+1)'(WINDOW_DEPTH);
		end
		slot = slot_raw[PTR_W-1:0];
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		ring_we   = 1'b0;
		div_start = 1'b0;
		out_free  = !out_valid_q || out_ready;
		unique case (state_q)
			mavg_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = mavg_pkg::ST_CHECK;
				end
			end
			mavg_pkg::ST_CHECK: begin
				if (!jump && fill_q == CNT_W'(WINDOW_DEPTH)) begin
					state_d = mavg_pkg::ST_READ;
				end else begin
					state_d = mavg_pkg::ST_APPEND;
				end
			end
			mavg_pkg::ST_READ: begin
				state_d = mavg_pkg::ST_DROP;
			end
			mavg_pkg::ST_DROP: begin
				if (!appended_q) begin
					state_d = mavg_pkg::ST_APPEND;
				end else if ({1'b0, fill_q} > {1'b0, eff_len} + (CNT_W+1)'(1)) begin
					state_d = mavg_pkg::ST_READ;
				end else begin
					state_d = mavg_pkg::ST_DIV;
				end
			end
			mavg_pkg::ST_APPEND: begin
				ring_we = 1'b1;
				if (fill_q >= eff_len) begin
					state_d = mavg_pkg::ST_READ;
				end else begin
					state_d = mavg_pkg::ST_DIV;
				end
			end
			mavg_pkg::ST_DIV: begin
				div_start = 1'b1;
				state_d   = mavg_pkg::ST_WAIT;
			end
			mavg_pkg::ST_WAIT: begin
				if (div_done) begin
					state_d = mavg_pkg::ST_OUT;
				end
			end
			mavg_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = mavg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mavg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mavg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == mavg_pkg::ST_IDLE);

	// Window bookkeeping: the running-sum register is updated by both append and drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q   <= '0;
			fill_q     <= '0;
			sum_q      <= '0;
			newest_q   <= '0;
			appended_q <= 1'b0;
		end else begin
			unique case (state_q)
				mavg_pkg::ST_CHECK: begin
					appended_q <= 1'b0;
					if (jump) begin
						oldest_q <= '0;
						fill_q   <= '0;
						sum_q    <= '0;
					end
				end
				mavg_pkg::ST_DROP: begin
					sum_q  <= sum_q - SUM_W'(rd_q);
					fill_q <= fill_q - CNT_W'(1);
					if (oldest_q == PTR_W'(WINDOW_DEPTH - 1)) begin
						oldest_q <= '0;
					end else begin
						oldest_q <= oldest_q + PTR_W'(1);
					end
				end
				mavg_pkg::ST_APPEND: begin
					sum_q      <= sum_q + SUM_W'(smp_q);
					fill_q     <= fill_q + CNT_W'(1);
					newest_q   <= smp_q;
					appended_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Input sample capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_q <= sample;
		end
	end

	// Sample ring, registered read of the oldest entry
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot] <= smp_q;
		end
		rd_q <= ring_mem[oldest_q];
	end

	// Mean = sum / count, truncated toward zero
	mavg_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (sum_q),
		.denom    (fill_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mavg_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mavg_pkg::ST_OUT && out_free) begin
			average_q <= div_quo[SAMPLE_BITS-1:0];
			count_q   <= fill_q;
			full_q    <= (fill_q == eff_len);
		end
	end

	assign out_valid    = out_valid_q;
	assign average      = average_q;
	assign sample_count = count_q;
	assign window_full  = full_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("window count exceeds ring depth");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_count != '0 && sample_count <= CNT_W'(WINDOW_DEPTH)))
		else $error("result count out of range");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in progress");
`endif

endmodule
